// ----- hw/rtl/tmcg_pkg.sv -----
// ----------------------------------------------------------------------------
// tmcg_pkg
// Shared types and constants for the text mode character generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcg_pkg;

  localparam logic [2:0] KIND_WRITE_CELL    = 3'd0;
  localparam logic [2:0] KIND_WRITE_ATTR    = 3'd1;
  localparam logic [2:0] KIND_LOAD_FONT     = 3'd2;
  localparam logic [2:0] KIND_CLEAR         = 3'd3;
  localparam logic [2:0] KIND_RENDER_CELL   = 3'd4;
  localparam logic [2:0] KIND_RENDER_DIRECT = 3'd5;

  localparam logic [1:0] REG_GLYPH_WIDTH    = 2'd0;
  localparam logic [1:0] REG_INVERSE_CODE   = 2'd1;
  localparam logic [1:0] REG_UNDERLINE_CODE = 2'd2;

  localparam logic [15:0] BLANK_CELL    = 16'h2020;
  localparam logic [7:0]  UNDERLINE_BIT = 8'h80;

  // code * width + offset never exceeds 255 * 8 + 7
  localparam int FA_W = 11;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } cs_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tmcg_ram.sv -----
// ----------------------------------------------------------------------------
// tmcg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tmcg_cell_store.sv -----
// ----------------------------------------------------------------------------
// tmcg_cell_store
// Cell memory (attribute, character) with per-entry valid bits; an entry not
// valid reads as the fill value, which a clear sets to blank.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcg_cell_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tmcg_pkg::cs_ctl_t ctl,
  input  wire logic [AW-1:0]     addr,
  input  wire logic [15:0]       wdata,
  output logic      [15:0]       rdata
);

  logic [DEPTH-1:0] valid_r;
  logic [15:0]      fill_r;
  logic             vq_r;
  logic [15:0]      ram_q;

  tmcg_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr),
    .waddr (addr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
      vq_r    <= 1'b0;
    end else begin
      if (ctl.rd) begin
        vq_r <= valid_r[addr];
      end
      if (ctl.clr) begin
        valid_r <= '0;
        fill_r  <= tmcg_pkg::BLANK_CELL;
      end else if (ctl.wr) begin
        valid_r[addr] <= 1'b1;
      end
    end
  end

  assign rdata = vq_r ? ram_q : fill_r;

endmodule

`default_nettype wire

// ----- hw/rtl/text_mode_character_generator.sv -----
// ----------------------------------------------------------------------------
// text_mode_character_generator
// Character-cell text engine: cell memory, font store and glyph renderer.
// ----------------------------------------------------------------------------
// Sequence: a render of a stored cell first reads the cell in S_CELL, then
//   S_REDUCE wraps the font address into the font store, and S_EMIT sends bytes.
// Flow: a render holds the input until its last byte is loaded, sending one
//   byte per cycle while out_tready allows; an attribute write reads and
//   rewrites its cell through S_CELL; all other kinds finish in S_IDLE.
// Reset: synchronous, active low; cells read as zero at once, no sweep.
`default_nettype none

module text_mode_character_generator #(
  parameter int ROWS       = 4,
  parameter int COLS       = 32,
  parameter int FONT_DEPTH = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: row[1:0] cell_req[6:2] char_code[14:7] attr[22:15]
  //           font_addr[33:23] font_byte[41:34], zero fill above
  input  wire logic [47:0] in_tdata,
  // in_tuser: kind[2:0]
  input  wire logic [2:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: pixel_byte[7:0] page[9:8] column[17:10], zero fill above
  output logic      [23:0] out_tdata,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);

  localparam int CELL_DEPTH = ROWS * COLS;
  localparam int CAW = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
  localparam int FAW = $clog2(FONT_DEPTH);
  localparam int FA_W = tmcg_pkg::FA_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CELL   = 4'b0010,
    S_REDUCE = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  // input fields
  logic [2:0]  in_kind;
  logic [1:0]  in_row;
  logic [4:0]  in_cell;
  logic [7:0]  in_char;
  logic [7:0]  in_attr;
  logic [10:0] in_faddr;
  logic [7:0]  in_fbyte;

  assign in_kind  = in_tuser;
  assign in_row   = in_tdata[1:0];
  assign in_cell  = in_tdata[6:2];
  assign in_char  = in_tdata[14:7];
  assign in_attr  = in_tdata[22:15];
  assign in_faddr = in_tdata[33:23];
  assign in_fbyte = in_tdata[41:34];

  // configuration
  logic [3:0] glyph_width_r;
  logic [7:0] inverse_code_r;
  logic [7:0] underline_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r    <= 4'd6;
      inverse_code_r   <= 8'd1;
      underline_code_r <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_addr)
        tmcg_pkg::REG_GLYPH_WIDTH:    glyph_width_r    <= cfg_wdata[3:0];
        tmcg_pkg::REG_INVERSE_CODE:   inverse_code_r   <= cfg_wdata;
        tmcg_pkg::REG_UNDERLINE_CODE: underline_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [3:0] w_eff;
  always_comb begin
    if (glyph_width_r == 4'd0) begin
      w_eff = 4'd1;
    end else if (glyph_width_r > 4'd8) begin
      w_eff = 4'd8;
    end else begin
      w_eff = glyph_width_r;
    end
  end

  // control registers
  state_t            state_r, state_nxt;
  logic              rmw_r, rmw_nxt;
  logic [CAW-1:0]    idx_r, idx_nxt;
  logic [7:0]        attr_r, attr_nxt;
  logic [1:0]        row_r, row_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [FA_W-1:0]   fa_r, fa_nxt;
  logic [2:0]        j_r, j_nxt;
  logic [3:0]        w_r, w_nxt;

  // output register
  logic              out_valid_r;
  logic [17:0]       out_data_r;
  logic              out_last_r;
  logic              out_load;
  logic              out_free;
  logic [7:0]        pix;
  logic              last_byte;

  // memories
  tmcg_pkg::cs_ctl_t cs_ctl;
  logic [CAW-1:0]    cs_addr;
  logic [15:0]       cs_wdata;
  logic [15:0]       cs_rdata;
  logic              font_we;
  logic [7:0]        font_q;

  logic              accept;
  logic              in_range;
  logic [CAW-1:0]    in_idx;
  logic [31:0]       idx_full;

  assign accept   = in_tvalid && in_tready;
  assign in_range = (32'(in_row) < ROWS) && (32'(in_cell) < COLS);
  assign idx_full = 32'(in_row) * COLS + 32'(in_cell);
  assign in_idx   = idx_full[CAW-1:0];
  assign in_tready = (state_r == S_IDLE);

  assign out_free  = !out_valid_r || out_tready;
  assign last_byte = ({1'b0, j_r} + 4'd1) == w_r;

  always_comb begin
    if (attr_r == inverse_code_r) begin
      pix = ~font_q;
    end else if (attr_r == underline_code_r) begin
      pix = font_q | tmcg_pkg::UNDERLINE_BIT;
    end else begin
      pix = font_q;
    end
  end

  always_comb begin
    state_nxt = state_r;
    rmw_nxt   = rmw_r;
    idx_nxt   = idx_r;
    attr_nxt  = attr_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    fa_nxt    = fa_r;
    j_nxt     = j_r;
    w_nxt     = w_r;
    cs_ctl    = '0;
    cs_addr   = in_idx;
    cs_wdata  = {in_attr, in_char};
    font_we   = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          w_nxt   = w_eff;
          row_nxt = in_row;
          idx_nxt = in_idx;
          col_nxt = 8'(in_cell * w_eff);
          case (in_kind)
            tmcg_pkg::KIND_WRITE_CELL: begin
              cs_ctl.wr = in_range;
            end
            tmcg_pkg::KIND_WRITE_ATTR: begin
              if (in_range) begin
                cs_ctl.rd = 1'b1;
                rmw_nxt   = 1'b1;
                attr_nxt  = in_attr;
                state_nxt = S_CELL;
              end
            end
            tmcg_pkg::KIND_LOAD_FONT: begin
              font_we = (32'(in_faddr) < FONT_DEPTH);
            end
            tmcg_pkg::KIND_CLEAR: begin
              cs_ctl.clr = 1'b1;
            end
            tmcg_pkg::KIND_RENDER_CELL: begin
              if (in_range) begin
                cs_ctl.rd = 1'b1;
                rmw_nxt   = 1'b0;
                state_nxt = S_CELL;
              end
            end
            tmcg_pkg::KIND_RENDER_DIRECT: begin
              if (in_range) begin
                attr_nxt  = in_attr;
                fa_nxt    = FA_W'(in_char * w_eff);
                state_nxt = S_REDUCE;
              end
            end
            default: ;
          endcase
        end
      end
      S_CELL: begin
        cs_addr = idx_r;
        if (rmw_r) begin
          cs_ctl.wr = 1'b1;
          cs_wdata  = {attr_r, cs_rdata[7:0]};
          state_nxt = S_IDLE;
        end else begin
          attr_nxt  = cs_rdata[15:8];
          fa_nxt    = FA_W'(cs_rdata[7:0] * w_r);
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cs_addr = idx_r;
        if (32'(fa_r) >= FONT_DEPTH) begin
          fa_nxt = fa_r - FA_W'(FONT_DEPTH);
        end else begin
          j_nxt     = 3'd0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cs_addr = idx_r;
        if (out_free) begin
          out_load = 1'b1;
          col_nxt  = col_r + 8'd1;
          j_nxt    = j_r + 3'd1;
          if (32'(fa_r) + 1 == FONT_DEPTH) begin
            fa_nxt = '0;
          end else begin
            fa_nxt = fa_r + FA_W'(1);
          end
          if (last_byte) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rmw_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rmw_r   <= rmw_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    attr_r <= attr_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    fa_r   <= fa_nxt;
    j_r    <= j_nxt;
    w_r    <= w_nxt;
    if (out_load) begin
      out_data_r <= {col_r, row_r, pix};
      out_last_r <= last_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};
  assign out_tlast  = out_last_r;

  tmcg_cell_store #(
    .DEPTH (CELL_DEPTH),
    .AW    (CAW)
  ) u_cells (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cs_ctl),
    .addr  (cs_addr),
    .wdata (cs_wdata),
    .rdata (cs_rdata)
  );

  // read address follows the next address so data matches fa_r each cycle
  tmcg_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (FAW'(in_faddr)),
    .wdata (in_fbyte),
    .raddr (FAW'(fa_nxt)),
    .rdata (font_q)
  );

  a_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> state_r == S_EMIT)
    else $error("beat loaded outside emit");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_byte) |=> (state_r == S_IDLE && out_valid_r && out_tlast))
    else $error("glyph end not followed by idle");

  a_fa_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> 32'(fa_r) < FONT_DEPTH)
    else $error("font address out of range while emitting");

  a_j_below_w: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> ({1'b0, j_r} < w_r))
    else $error("byte index past glyph width");

endmodule

`default_nettype wire
